>>> src/haar_2d_forward_subband_stream_macros.svh
// Assertion helpers for the checker file.
`ifndef HAAR_2D_FORWARD_SUBBAND_STREAM_MACROS_SVH
`define HAAR_2D_FORWARD_SUBBAND_STREAM_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define HFS_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hfs assertion failed");

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define HFS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hfs assertion failed");

`endif

>>> src/hfs_pkg.sv
`default_nettype none

package hfs_pkg;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  localparam int unsigned CFG_W   = 12;
  localparam int unsigned SIZE_W  = 14;
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned LL_W    = 11;
  localparam int unsigned DET_W   = 12;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned ROW_W   = 11;
  localparam int unsigned PROD_W  = 17;

  localparam logic [CFG_W-1:0]  SIZE_RESET = 12'd2048;
  localparam logic [SIZE_W-1:0] MAX_HEIGHT = 14'd2048;
  localparam logic [SIZE_W-1:0] MIN_SIZE   = 14'd2;

  localparam logic signed [PROD_W-1:0] LL_MAX  = 17'sd1023;
  localparam logic signed [PROD_W-1:0] LL_MIN  = -17'sd1024;
  localparam logic signed [PROD_W-1:0] DET_MAX = 17'sd2047;
  localparam logic signed [PROD_W-1:0] DET_MIN = -17'sd2048;
  localparam logic signed [PROD_W-1:0] LL_BIAS = 17'sd512;

  typedef struct packed {
    logic             odd_col;
    logic             odd_row;
    logic [POS_W-1:0] block_x;
    logic [POS_W-1:0] block_y;
    logic             frame_end;
  } beat_ctl_t;

  // Halve, rounding half away from zero.
  function automatic logic signed [PROD_W-1:0] half_round(input logic signed [PROD_W-1:0] t);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] h;
    mag = t[PROD_W-1] ? PROD_W'(-t) : PROD_W'(t);
    h   = (mag + PROD_W'(1)) >> 1;
    return t[PROD_W-1] ? -$signed(h) : $signed(h);
  endfunction

  // Clamp an even-masked size register to [2, lim].
  function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] r,
                                                  input logic [SIZE_W-1:0] lim);
    logic [SIZE_W-1:0] v;
    v = {{(SIZE_W-CFG_W){1'b0}}, r[CFG_W-1:1], 1'b0};
    if (v < MIN_SIZE) v = MIN_SIZE;
    if (v > lim) v = lim;
    return v;
  endfunction

endpackage

`default_nettype wire

>>> src/hfs_line_store.sv
`default_nettype none

module hfs_line_store #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = 11
) (
  input  wire logic                      clk_i,
  input  wire logic                      wr_en_i,
  input  wire logic [AW-1:0]             wr_addr_i,
  input  wire logic [hfs_pkg::PIX_W-1:0] wr_data_i,
  input  wire logic                      rd_en_i,
  input  wire logic [AW-1:0]             rd_addr_i,
  output logic      [hfs_pkg::PIX_W-1:0] rd_data_o
);

  logic [hfs_pkg::PIX_W-1:0] mem [DEPTH];
  logic [hfs_pkg::PIX_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> src/hfs_coef.sv
`default_nettype none

module hfs_coef #(
  parameter int unsigned LL_GAIN     = 4,
  parameter int unsigned DETAIL_GAIN = 8
) (
  input  wire logic        [hfs_pkg::PIX_W-1:0] a_i,
  input  wire logic        [hfs_pkg::PIX_W-1:0] b_i,
  input  wire logic        [hfs_pkg::PIX_W-1:0] c_i,
  input  wire logic        [hfs_pkg::PIX_W-1:0] d_i,
  output logic signed [hfs_pkg::LL_W-1:0]       ll_o,
  output logic signed [hfs_pkg::DET_W-1:0]      hl_o,
  output logic signed [hfs_pkg::DET_W-1:0]      lh_o,
  output logic signed [hfs_pkg::DET_W-1:0]      hh_o
);

  localparam int unsigned PW = hfs_pkg::PROD_W;
  localparam logic signed [PW-1:0] LLG = PW'(LL_GAIN);
  localparam logic signed [PW-1:0] DG  = PW'(DETAIL_GAIN);

  logic signed [PW-1:0] a, b, c, d;
  logic signed [PW-1:0] s_ll, s_hl, s_lh, s_hh;
  logic signed [PW-1:0] r_ll, r_hl, r_lh, r_hh;
  logic signed [PW-1:0] t_ll, t_hl, t_lh, t_hh;

  always_comb begin
    a = $signed({{(PW-hfs_pkg::PIX_W){1'b0}}, a_i});
    b = $signed({{(PW-hfs_pkg::PIX_W){1'b0}}, b_i});
    c = $signed({{(PW-hfs_pkg::PIX_W){1'b0}}, c_i});
    d = $signed({{(PW-hfs_pkg::PIX_W){1'b0}}, d_i});
    s_ll = a + b + c + d - hfs_pkg::LL_BIAS;
    s_hl = a - b + c - d;
    s_lh = a + b - c - d;
    s_hh = a - b - c + d;
    r_ll = hfs_pkg::half_round(PW'(s_ll * LLG));
    r_hl = hfs_pkg::half_round(PW'(s_hl * DG));
    r_lh = hfs_pkg::half_round(PW'(s_lh * DG));
    r_hh = hfs_pkg::half_round(PW'(s_hh * DG));
    // saturate to field range
    t_ll = (r_ll > hfs_pkg::LL_MAX) ? hfs_pkg::LL_MAX :
           (r_ll < hfs_pkg::LL_MIN) ? hfs_pkg::LL_MIN : r_ll;
    t_hl = (r_hl > hfs_pkg::DET_MAX) ? hfs_pkg::DET_MAX :
           (r_hl < hfs_pkg::DET_MIN) ? hfs_pkg::DET_MIN : r_hl;
    t_lh = (r_lh > hfs_pkg::DET_MAX) ? hfs_pkg::DET_MAX :
           (r_lh < hfs_pkg::DET_MIN) ? hfs_pkg::DET_MIN : r_lh;
    t_hh = (r_hh > hfs_pkg::DET_MAX) ? hfs_pkg::DET_MAX :
           (r_hh < hfs_pkg::DET_MIN) ? hfs_pkg::DET_MIN : r_hh;
    ll_o = t_ll[hfs_pkg::LL_W-1:0];
    hl_o = t_hl[hfs_pkg::DET_W-1:0];
    lh_o = t_lh[hfs_pkg::DET_W-1:0];
    hh_o = t_hh[hfs_pkg::DET_W-1:0];
  end

endmodule

`default_nettype wire

>>> src/haar_2d_forward_subband_stream.sv
// A block result is registered in stage one, then at the output. One pixel beat per clock
// is accepted unless the output stalls; a coefficient beat closes every second odd-row pixel.
// The line store has one write and one read port, used by even and odd rows.
// Reset: counters and pipeline valids clear, both size registers return to 2048.
// The line store is not cleared; an odd row reads what the even row above wrote.
`default_nettype none

module haar_2d_forward_subband_stream #(
  parameter int unsigned MAX_WIDTH   = 2048,
  parameter int unsigned LL_GAIN     = 4,
  parameter int unsigned DETAIL_GAIN = 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic                             cfg_idx_i,
  input  wire logic        [hfs_pkg::CFG_W-1:0] cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic        [hfs_pkg::PIX_W-1:0] pixel_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic signed      [hfs_pkg::LL_W-1:0]  coef_ll_o,
  output logic signed      [hfs_pkg::DET_W-1:0] coef_hl_o,
  output logic signed      [hfs_pkg::DET_W-1:0] coef_lh_o,
  output logic signed      [hfs_pkg::DET_W-1:0] coef_hh_o,
  output logic             [hfs_pkg::POS_W-1:0] block_x_o,
  output logic             [hfs_pkg::POS_W-1:0] block_y_o,
  output logic                                  frame_end_o
);

  localparam int unsigned CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned SW = hfs_pkg::SIZE_W;
  localparam logic [SW-1:0] W_LIM = SW'(MAX_WIDTH - (MAX_WIDTH % 2));

  logic [hfs_pkg::CFG_W-1:0] width_q, height_q;
  logic [CW-1:0]             col_q, col_d;
  logic [hfs_pkg::ROW_W-1:0] row_q, row_d;
  logic [SW-1:0]             w_eff, h_eff, col_ext, row_ext;
  logic [CW+10:0]            col_wide;
  logic                      row_last, frm_last;
  logic                      in_acc;

  hfs_pkg::beat_ctl_t        s1_ctl_q, s1_ctl_d;
  logic                      s1_vld_q, s1_go, s1_emit;
  logic [hfs_pkg::PIX_W-1:0] s1_pix_q, a_q, c_q, rd_data;

  logic signed [hfs_pkg::LL_W-1:0]  ll_c;
  logic signed [hfs_pkg::DET_W-1:0] hl_c, lh_c, hh_c;
  logic                             out_vld_q, out_vld_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= hfs_pkg::SIZE_RESET;
      height_q <= hfs_pkg::SIZE_RESET;
    end else if (cfg_we_i) begin
      case (hfs_pkg::reg_idx_e'(cfg_idx_i))
        hfs_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        hfs_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff    = hfs_pkg::eff_size(width_q, W_LIM);
    h_eff    = hfs_pkg::eff_size(height_q, hfs_pkg::MAX_HEIGHT);
    col_ext  = SW'(col_q);
    row_ext  = SW'(row_q);
    col_wide = (CW + 11)'(col_q);
    row_last = col_ext >= (w_eff - SW'(1));
    frm_last = row_ext >= (h_eff - SW'(1));
    col_d    = row_last ? '0 : col_q + CW'(1);
    row_d    = row_last ? (frm_last ? '0 : row_q + hfs_pkg::ROW_W'(1)) : row_q;
    s1_ctl_d.odd_col   = col_q[0];
    s1_ctl_d.odd_row   = row_q[0];
    s1_ctl_d.block_x   = col_wide[10:1];
    s1_ctl_d.block_y   = row_q[hfs_pkg::ROW_W-1:1];
    s1_ctl_d.frame_end = row_last & frm_last;
  end

  assign s1_emit    = s1_ctl_q.odd_col & s1_ctl_q.odd_row;
  assign s1_go      = s1_vld_q & (~s1_emit | ~out_vld_q | out_ready_i);
  assign in_ready_o = ~s1_vld_q | s1_go;
  assign in_acc     = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      s1_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (in_acc || s1_go) begin
        s1_vld_q <= in_acc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q <= pixel_i;
      s1_ctl_q <= s1_ctl_d;
    end
  end

  hfs_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_store (
    .clk_i     (clk_i),
    .wr_en_i   (in_acc & ~row_q[0]),
    .wr_addr_i (col_q),
    .wr_data_i (pixel_i),
    .rd_en_i   (in_acc & row_q[0]),
    .rd_addr_i (col_q),
    .rd_data_o (rd_data)
  );

  // Hold the left column of the block until its right pixel arrives.
  always_ff @(posedge clk_i) begin
    if (s1_go && !s1_ctl_q.odd_col) begin
      c_q <= s1_pix_q;
      if (s1_ctl_q.odd_row) begin
        a_q <= rd_data;
      end
    end
  end

  hfs_coef #(
    .LL_GAIN     (LL_GAIN),
    .DETAIL_GAIN (DETAIL_GAIN)
  ) u_coef (
    .a_i  (a_q),
    .b_i  (rd_data),
    .c_i  (c_q),
    .d_i  (s1_pix_q),
    .ll_o (ll_c),
    .hl_o (hl_c),
    .lh_o (lh_c),
    .hh_o (hh_c)
  );

  assign out_vld_d = (s1_go & s1_emit) | (out_vld_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_emit) begin
      coef_ll_o   <= ll_c;
      coef_hl_o   <= hl_c;
      coef_lh_o   <= lh_c;
      coef_hh_o   <= hh_c;
      block_x_o   <= s1_ctl_q.block_x;
      block_y_o   <= s1_ctl_q.block_y;
      frame_end_o <= s1_ctl_q.frame_end;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

`default_nettype wire

>>> src/hfs_checker.sv
`default_nettype none
`include "haar_2d_forward_subband_stream_macros.svh"

module hfs_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             in_valid_i,
  input wire logic                             in_ready_o,
  input wire logic                             out_valid_o,
  input wire logic                             out_ready_i,
  input wire logic signed [hfs_pkg::LL_W-1:0]  coef_ll_o,
  input wire logic signed [hfs_pkg::DET_W-1:0] coef_hl_o,
  input wire logic signed [hfs_pkg::DET_W-1:0] coef_lh_o,
  input wire logic signed [hfs_pkg::DET_W-1:0] coef_hh_o,
  input wire logic        [hfs_pkg::POS_W-1:0] block_x_o,
  input wire logic        [hfs_pkg::POS_W-1:0] block_y_o,
  input wire logic                             frame_end_o
);

  // A stalled result beat holds.
  `HFS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(coef_ll_o) && $stable(coef_hl_o) && $stable(coef_lh_o) &&
    $stable(coef_hh_o) && $stable(block_x_o) && $stable(block_y_o) && $stable(frame_end_o))

  // Input backs up only behind a stalled result.
  `HFS_ASSERT_NOW(a_stall_cause, !in_ready_o, out_valid_o && !out_ready_i)

  // A new result traces back to an accepted pixel beat through stage one and the output register.
  `HFS_ASSERT_NOW(a_out_source, $rose(out_valid_o), $past(in_valid_i && in_ready_o, 2))

endmodule

bind haar_2d_forward_subband_stream hfs_checker u_hfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .coef_ll_o   (coef_ll_o),
  .coef_hl_o   (coef_hl_o),
  .coef_lh_o   (coef_lh_o),
  .coef_hh_o   (coef_hh_o),
  .block_x_o   (block_x_o),
  .block_y_o   (block_y_o),
  .frame_end_o (frame_end_o)
);

`default_nettype wire

>>> dv/haar_2d_forward_subband_stream_tb.sv
`timescale 1ns / 1ps

typedef struct packed {
  logic signed [hfs_pkg::LL_W-1:0]  ll;
  logic signed [hfs_pkg::DET_W-1:0] hl;
  logic signed [hfs_pkg::DET_W-1:0] lh;
  logic signed [hfs_pkg::DET_W-1:0] hh;
  logic        [hfs_pkg::POS_W-1:0] block_x;
  logic        [hfs_pkg::POS_W-1:0] block_y;
  logic                             frame_end;
} coef_beat_t;

class haar_scoreboard;
  localparam int unsigned MAX_WIDTH   = 2048;
  localparam int unsigned MAX_FRAME_H = 2048;
  localparam int          LL_GAIN     = 4;
  localparam int          DETAIL_GAIN = 8;
  localparam int          LL_HI       = 1023;
  localparam int          DET_HI      = 2047;
  localparam int unsigned PRINT_CAP   = 40;

  logic [hfs_pkg::CFG_W-1:0] width_reg;
  logic [hfs_pkg::CFG_W-1:0] height_reg;
  logic [hfs_pkg::PIX_W-1:0] line_store [MAX_WIDTH];
  logic [hfs_pkg::PIX_W-1:0] held_pixel;
  int unsigned               col_cnt;
  int unsigned               row_cnt;
  coef_beat_t                expected_beats [$];
  int unsigned               mismatches;
  int unsigned               pixel_beats;
  int unsigned               coef_beats;
  int unsigned               frame_ends;

  function new();
    width_reg  = hfs_pkg::SIZE_RESET;
    height_reg = hfs_pkg::SIZE_RESET;
    foreach (line_store[i]) line_store[i] = '0;
    held_pixel  = '0;
    col_cnt     = 0;
    row_cnt     = 0;
    mismatches  = 0;
    pixel_beats = 0;
    coef_beats  = 0;
    frame_ends  = 0;
  endfunction

  function int unsigned clamp_size(logic [hfs_pkg::CFG_W-1:0] r, int unsigned lim);
    int unsigned v;
    v = {r[hfs_pkg::CFG_W-1:1], 1'b0};
    if (v < 2) v = 2;
    if (v > lim) v = lim;
    return v;
  endfunction

  // Halve, round half away from zero, saturate to [-hi-1, hi].
  function int half_sat(int t, int hi);
    int r;
    r = (t >= 0) ? (t + 1) / 2 : -((-t + 1) / 2);
    if (r > hi) r = hi;
    if (r < -hi - 1) r = -hi - 1;
    return r;
  endfunction

  function void write_reg(hfs_pkg::reg_idx_e idx, logic [hfs_pkg::CFG_W-1:0] value);
    if (idx == hfs_pkg::REG_FRAME_WIDTH) begin
      width_reg = value;
    end else begin
      height_reg = value;
    end
  endfunction

  function int unsigned pixels_to_frame_end();
    int unsigned w;
    int unsigned h;
    int unsigned n;
    w = clamp_size(width_reg, MAX_WIDTH);
    h = clamp_size(height_reg, MAX_FRAME_H);
    n = (col_cnt >= w - 1) ? 1 : w - col_cnt;
    if (row_cnt < h - 1) n += (h - 1 - row_cnt) * w;
    return n;
  endfunction

  function void note_pixel(logic [hfs_pkg::PIX_W-1:0] px);
    int unsigned w;
    int unsigned h;
    bit          row_end;
    int          a;
    int          b;
    int          c;
    int          d;
    coef_beat_t  beat;
    w = clamp_size(width_reg, MAX_WIDTH);
    h = clamp_size(height_reg, MAX_FRAME_H);
    row_end = col_cnt >= w - 1;
    pixel_beats++;
    if (row_cnt % 2 == 0) begin
      line_store[col_cnt] = px;
    end else if (col_cnt % 2 == 1) begin
      a = line_store[col_cnt - 1];
      b = line_store[col_cnt];
      c = held_pixel;
      d = px;
      beat.ll        = hfs_pkg::LL_W'(half_sat(LL_GAIN * (a + b + c + d - 512), LL_HI));
      beat.hl        = hfs_pkg::DET_W'(half_sat(DETAIL_GAIN * (a - b + c - d), DET_HI));
      beat.lh        = hfs_pkg::DET_W'(half_sat(DETAIL_GAIN * (a + b - c - d), DET_HI));
      beat.hh        = hfs_pkg::DET_W'(half_sat(DETAIL_GAIN * (a - b - c + d), DET_HI));
      beat.block_x   = hfs_pkg::POS_W'(col_cnt >> 1);
      beat.block_y   = hfs_pkg::POS_W'(row_cnt >> 1);
      beat.frame_end = row_end && (row_cnt >= h - 1);
      if (beat.frame_end) frame_ends++;
      expected_beats.push_back(beat);
    end
    if (col_cnt % 2 == 0) held_pixel = px;
    if (row_end) begin
      col_cnt = 0;
      row_cnt = (row_cnt >= h - 1) ? 0 : row_cnt + 1;
    end else begin
      col_cnt++;
    end
  endfunction

  task report(string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("MISMATCH %0t: %s", $time, msg);
  endtask

  task check_beat(coef_beat_t got);
    coef_beat_t want;
    if (expected_beats.size() == 0) begin
      report($sformatf("coefficient beat with none pending, x=%0d y=%0d",
                       got.block_x, got.block_y));
      return;
    end
    want = expected_beats.pop_front();
    coef_beats++;
    if (got.ll !== want.ll)
      report($sformatf("ll got %0d want %0d", got.ll, want.ll));
    if (got.hl !== want.hl)
      report($sformatf("hl got %0d want %0d", got.hl, want.hl));
    if (got.lh !== want.lh)
      report($sformatf("lh got %0d want %0d", got.lh, want.lh));
    if (got.hh !== want.hh)
      report($sformatf("hh got %0d want %0d", got.hh, want.hh));
    if (got.block_x !== want.block_x)
      report($sformatf("block_x got %0d want %0d", got.block_x, want.block_x));
    if (got.block_y !== want.block_y)
      report($sformatf("block_y got %0d want %0d", got.block_y, want.block_y));
    if (got.frame_end !== want.frame_end)
      report($sformatf("frame_end got %0b want %0b at x=%0d y=%0d",
                       got.frame_end, want.frame_end, want.block_x, want.block_y));
  endtask
endclass

module haar_2d_forward_subband_stream_tb;

  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned RANDOM_PIXELS = 1000;
  localparam int unsigned QUIET_TAIL    = 250;
  localparam int unsigned LONG_HOLD     = 400;

  // Two 6x2 frames: blocks all-dark, all-bright, then max/min horizontal,
  // max vertical and max diagonal detail.
  localparam logic [hfs_pkg::PIX_W-1:0] DIRECTED_PIXELS [24] = '{
    8'd0, 8'd0,   8'd255, 8'd255, 8'd255, 8'd0,
    8'd0, 8'd0,   8'd255, 8'd255, 8'd255, 8'd0,
    8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0,
    8'd0, 8'd255, 8'd0,   8'd0,   8'd0,   8'd255
  };

  logic                             clk_i;
  logic                             rst_ni      = 1'b0;
  logic                             cfg_we_i    = 1'b0;
  logic                             cfg_idx_i   = hfs_pkg::REG_FRAME_WIDTH;
  logic [hfs_pkg::CFG_W-1:0]        cfg_data_i  = '0;
  logic                             in_valid_i  = 1'b0;
  logic                             in_ready_o;
  logic [hfs_pkg::PIX_W-1:0]        pixel_i     = '0;
  logic                             out_valid_o;
  logic                             out_ready_i = 1'b0;
  logic signed [hfs_pkg::LL_W-1:0]  coef_ll_o;
  logic signed [hfs_pkg::DET_W-1:0] coef_hl_o;
  logic signed [hfs_pkg::DET_W-1:0] coef_lh_o;
  logic signed [hfs_pkg::DET_W-1:0] coef_hh_o;
  logic [hfs_pkg::POS_W-1:0]        block_x_o;
  logic [hfs_pkg::POS_W-1:0]        block_y_o;
  logic                             frame_end_o;

  haar_scoreboard sb = new();
  bit             tx_gaps  = 1'b1;
  bit             rx_gaps  = 1'b1;
  bit             hold_req = 1'b0;
  int unsigned    reg_writes = 0;
  int unsigned    cycles     = 0;

  haar_2d_forward_subband_stream dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pixel_i     (pixel_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .coef_ll_o   (coef_ll_o),
    .coef_hl_o   (coef_hl_o),
    .coef_lh_o   (coef_lh_o),
    .coef_hh_o   (coef_hh_o),
    .block_x_o   (block_x_o),
    .block_y_o   (block_y_o),
    .frame_end_o (frame_end_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  task automatic send_pixel(logic [hfs_pkg::PIX_W-1:0] v);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_pixel(v);
  endtask

  task automatic send_random(int unsigned n);
    repeat (n) send_pixel(hfs_pkg::PIX_W'($urandom_range(0, 255)));
    in_valid_i <= 1'b0;
  endtask

  // Drain every pending beat, then let in-flight pixels with no result retire.
  task automatic settle();
    while (sb.expected_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(hfs_pkg::reg_idx_e idx, logic [hfs_pkg::CFG_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    sb.write_reg(idx, value);
    reg_writes++;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [hfs_pkg::CFG_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0: return hfs_pkg::CFG_W'($urandom_range(0, 3));
      1: return hfs_pkg::CFG_W'($urandom());
      default: return hfs_pkg::CFG_W'($urandom_range(2, 24));
    endcase
  endfunction

  initial begin : coef_sink
    int unsigned stall_left;
    coef_beat_t  got;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got.ll        = coef_ll_o;
        got.hl        = coef_hl_o;
        got.lh        = coef_lh_o;
        got.hh        = coef_hh_o;
        got.block_x   = block_x_o;
        got.block_y   = block_y_o;
        got.frame_end = frame_end_o;
        sb.check_beat(got);
      end
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && rx_gaps && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 12);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d beats pending", cycles,
             sb.expected_beats.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    int unsigned random_pixels;
    int unsigned n;
    bit          quiet;
    bit          wide_ok;
    random_pixels = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(hfs_pkg::REG_FRAME_WIDTH, hfs_pkg::CFG_W'(6));
    write_reg(hfs_pkg::REG_FRAME_HEIGHT, hfs_pkg::CFG_W'(2));
    foreach (DIRECTED_PIXELS[i]) send_pixel(DIRECTED_PIXELS[i]);
    in_valid_i <= 1'b0;

    // undersized and odd sizes
    settle();
    write_reg(hfs_pkg::REG_FRAME_WIDTH, hfs_pkg::CFG_W'(1));
    write_reg(hfs_pkg::REG_FRAME_HEIGHT, hfs_pkg::CFG_W'(0));
    send_random(4);
    settle();
    write_reg(hfs_pkg::REG_FRAME_WIDTH, hfs_pkg::CFG_W'(7));
    write_reg(hfs_pkg::REG_FRAME_HEIGHT, hfs_pkg::CFG_W'(3));
    send_random(12);
    settle();
    write_reg(hfs_pkg::REG_FRAME_WIDTH, hfs_pkg::CFG_W'(0));
    write_reg(hfs_pkg::REG_FRAME_HEIGHT, hfs_pkg::CFG_W'(1));
    send_random(4);

    // oversized sizes clamp to full width; start a full-width row
    settle();
    write_reg(hfs_pkg::REG_FRAME_WIDTH, hfs_pkg::CFG_W'(4095));
    write_reg(hfs_pkg::REG_FRAME_HEIGHT, hfs_pkg::CFG_W'(4095));
    tx_gaps = 1'b0;
    send_random(40);

    // shrink width mid-row: the next pixel closes the row
    settle();
    write_reg(hfs_pkg::REG_FRAME_WIDTH, hfs_pkg::CFG_W'(6));
    send_random(1 + 6);

    // shrink height past the current row: frame closes at row end
    settle();
    write_reg(hfs_pkg::REG_FRAME_HEIGHT, hfs_pkg::CFG_W'(8));
    send_random(sb.pixels_to_frame_end() + 5 * 6);
    settle();
    write_reg(hfs_pkg::REG_FRAME_HEIGHT, hfs_pkg::CFG_W'(4));
    send_random(sb.pixels_to_frame_end());

    // long output stall while pixels keep coming
    settle();
    write_reg(hfs_pkg::REG_FRAME_WIDTH, hfs_pkg::CFG_W'(8));
    write_reg(hfs_pkg::REG_FRAME_HEIGHT, hfs_pkg::CFG_W'(4));
    rx_gaps  = 1'b0;
    hold_req = 1'b1;
    send_random(160);

    while (random_pixels < RANDOM_PIXELS) begin
      settle();
      quiet   = random_pixels + QUIET_TAIL >= RANDOM_PIXELS;
      tx_gaps = !quiet && $urandom_range(0, 2) != 0;
      rx_gaps = !quiet && $urandom_range(0, 2) != 0;
      // change width only on an even row so an odd row never reads an unwritten column
      wide_ok = sb.row_cnt % 2 == 0;
      case ($urandom_range(0, 3))
        0: if (wide_ok) write_reg(hfs_pkg::REG_FRAME_WIDTH, pick_size());
        1: write_reg(hfs_pkg::REG_FRAME_HEIGHT, pick_size());
        2: begin
          if (wide_ok) write_reg(hfs_pkg::REG_FRAME_WIDTH, pick_size());
          write_reg(hfs_pkg::REG_FRAME_HEIGHT, pick_size());
        end
        default: ;
      endcase
      n = sb.pixels_to_frame_end();
      if (n > 200 || $urandom_range(0, 2) == 0) n = $urandom_range(1, 120);
      send_random(n);
      random_pixels += n;
    end

    settle();
    $display("covered %0d pixel beats, %0d coefficient beats, %0d frame ends",
             sb.pixel_beats, sb.coef_beats, sb.frame_ends);
    $display("%0d size writes incl. odd, undersized, oversized and mid-frame; %0d mismatches",
             reg_writes, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_beats.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
